>>> rtl/ipv4_text_address_parser_defines.svh
// Assertion macros shared by the dotted-decimal address parser RTL.
// Depends on nothing; included by the top level only.
`ifndef IPV4_TEXT_ADDRESS_PARSER_DEFINES_SVH
`define IPV4_TEXT_ADDRESS_PARSER_DEFINES_SVH

// Same-cycle implication, checked on every rising clock edge outside reset.
`define IPV4P_ASSERT_NOW(label, clk_sig, rst_sig, ante, cons) \
  label: assert property (@(posedge clk_sig) disable iff (rst_sig) (ante) |-> (cons)) \
    else $error("ipv4 parser assertion failed");

// Next-cycle implication, checked on every rising clock edge outside reset.
`define IPV4P_ASSERT_NEXT(label, clk_sig, rst_sig, ante, cons) \
  label: assert property (@(posedge clk_sig) disable iff (rst_sig) (ante) |=> (cons)) \
    else $error("ipv4 parser assertion failed");

`endif

>>> rtl/ipv4p_pkg.sv
// Package of the dotted-decimal address parser: token type, queue status and
// character classification. Depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

package ipv4p_pkg;

  localparam int unsigned QUEUE_DEPTH = 2;
  localparam int unsigned OCTET_COUNT = 4;
  localparam logic [7:0]  CHAR_ZERO   = 8'h30;
  localparam logic [7:0]  CHAR_NINE   = 8'h39;
  localparam logic [7:0]  CHAR_DOT    = 8'h2E;
  localparam logic [7:0]  OCTET_MAX   = 8'd255;

  typedef enum logic [1:0] {
    TK_DIGIT,
    TK_DOT,
    TK_OTHER,
    TK_EOT
  } token_kind_t;

  typedef struct packed {
    token_kind_t kind;
    logic [3:0]  digit;
  } token_t;

  typedef struct packed {
    logic full;
    logic empty;
  } queue_status_t;

  function automatic token_t classify(input logic [7:0] ch, input logic eot);
    token_t     tok;
    logic [7:0] diff;
    diff      = ch - CHAR_ZERO;
    tok.digit = diff[3:0];
    if (eot) begin
      tok.kind = TK_EOT;
    end else if (ch >= CHAR_ZERO && ch <= CHAR_NINE) begin
      tok.kind = TK_DIGIT;
    end else if (ch == CHAR_DOT) begin
      tok.kind = TK_DOT;
    end else begin
      tok.kind = TK_OTHER;
    end
    return tok;
  endfunction

endpackage

`default_nettype wire

>>> rtl/ipv4p_front.sv
// Front stage: accepts text items, classifies each into a token and holds it
// in a register until the queue takes it. Depends on ipv4p_pkg.
`timescale 1ns / 1ps
`default_nettype none

module ipv4p_front (
  input  wire               clk,
  input  wire               rst,
  input  wire               in_valid,
  output logic              in_ready,
  input  wire  [7:0]        in_char,
  input  wire               in_eot,
  output logic              tok_valid,
  input  wire               tok_ready,
  output ipv4p_pkg::token_t tok
);

  logic stage_valid;

  assign in_ready  = !stage_valid || tok_ready;
  assign tok_valid = stage_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
    end else if (in_ready) begin
      stage_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      tok <= ipv4p_pkg::classify(in_char, in_eot);
    end
  end

endmodule

`default_nettype wire

>>> rtl/ipv4p_queue.sv
// Short register queue that parts the front stage from the parser back end.
// Depends on ipv4p_pkg.
`timescale 1ns / 1ps
`default_nettype none

module ipv4p_queue #(
  parameter int unsigned DEPTH = ipv4p_pkg::QUEUE_DEPTH
) (
  input  wire                      clk,
  input  wire                      rst,
  input  wire                      push_valid,
  output logic                     push_ready,
  input  ipv4p_pkg::token_t        push_data,
  output logic                     pop_valid,
  input  wire                      pop_ready,
  output ipv4p_pkg::token_t        pop_data,
  output ipv4p_pkg::queue_status_t status
);

  localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  ipv4p_pkg::token_t entries [DEPTH];
  logic [PW-1:0]     wr_ptr;
  logic [PW-1:0]     rd_ptr;
  logic [CW-1:0]     count;
  logic              do_push;
  logic              do_pop;

  assign status.full  = (count == CW'(DEPTH));
  assign status.empty = (count == '0);
  assign push_ready   = !status.full;
  assign pop_valid    = !status.empty;
  assign pop_data     = entries[rd_ptr];
  assign do_push      = push_valid && push_ready;
  assign do_pop       = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= push_data;
    end
  end

endmodule

`default_nettype wire

>>> rtl/ipv4p_back.sv
// Back end: runs the octet parser on tokens from the queue and holds each
// result in an output register. Depends on ipv4p_pkg.
`timescale 1ns / 1ps
`default_nettype none

module ipv4p_back (
  input  wire               clk,
  input  wire               rst,
  input  wire               tok_valid,
  output logic              tok_ready,
  input  ipv4p_pkg::token_t tok,
  output logic              res_valid,
  input  wire               res_ready,
  output logic              res_addr_valid,
  output logic [31:0]       res_addr_value
);

  logic [2:0]  octets_done,       octets_done_next;
  logic [7:0]  octet_accumulator, octet_accumulator_next;
  logic [1:0]  digit_count,       digit_count_next;
  logic        first_digit_zero,  first_digit_zero_next;
  logic        fault_seen,        fault_seen_next;
  logic [31:0] address_shift,     address_shift_next;

  logic        out_free;
  logic        take;
  logic        load_result;
  logic        close_ok;
  logic [11:0] acc_times_ten;
  logic        result_ok;

  assign out_free    = !res_valid || res_ready;
  assign tok_ready   = (tok.kind != ipv4p_pkg::TK_EOT) || out_free;
  assign take        = tok_valid && tok_ready;
  assign load_result = take && (tok.kind == ipv4p_pkg::TK_EOT);

  assign close_ok = !fault_seen && (octets_done < 3'(ipv4p_pkg::OCTET_COUNT))
                    && (digit_count != 2'd0);
  assign acc_times_ten = {1'b0, octet_accumulator, 3'b000}
                         + {3'b000, octet_accumulator, 1'b0}
                         + {8'h00, tok.digit};
  assign result_ok = close_ok && (octets_done == 3'(ipv4p_pkg::OCTET_COUNT - 1));

  always_comb begin
    octets_done_next       = octets_done;
    octet_accumulator_next = octet_accumulator;
    digit_count_next       = digit_count;
    first_digit_zero_next  = first_digit_zero;
    fault_seen_next        = fault_seen;
    address_shift_next     = address_shift;
    unique case (tok.kind)
      ipv4p_pkg::TK_DIGIT: begin
        if (!fault_seen) begin
          if (digit_count == 2'd0) begin
            octet_accumulator_next = {4'h0, tok.digit};
            first_digit_zero_next  = (tok.digit == 4'd0);
            digit_count_next       = 2'd1;
          end else if (first_digit_zero || digit_count == 2'd3
                       || acc_times_ten > {4'h0, ipv4p_pkg::OCTET_MAX}) begin
            fault_seen_next = 1'b1;
          end else begin
            octet_accumulator_next = acc_times_ten[7:0];
            digit_count_next       = digit_count + 2'd1;
          end
        end
      end
      ipv4p_pkg::TK_DOT: begin
        if (close_ok) begin
          address_shift_next     = {address_shift[23:0], octet_accumulator};
          octets_done_next       = octets_done + 3'd1;
          octet_accumulator_next = 8'h00;
          digit_count_next       = 2'd0;
          first_digit_zero_next  = 1'b0;
        end else begin
          fault_seen_next = 1'b1;
        end
      end
      ipv4p_pkg::TK_OTHER: begin
        fault_seen_next = 1'b1;
      end
      ipv4p_pkg::TK_EOT: begin
        octets_done_next       = 3'd0;
        octet_accumulator_next = 8'h00;
        digit_count_next       = 2'd0;
        first_digit_zero_next  = 1'b0;
        fault_seen_next        = 1'b0;
        address_shift_next     = 32'h0;
      end
      default: begin
        fault_seen_next = 1'b1;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      octets_done       <= 3'd0;
      octet_accumulator <= 8'h00;
      digit_count       <= 2'd0;
      first_digit_zero  <= 1'b0;
      fault_seen        <= 1'b0;
      address_shift     <= 32'h0;
      res_valid         <= 1'b0;
    end else begin
      if (take) begin
        octets_done       <= octets_done_next;
        octet_accumulator <= octet_accumulator_next;
        digit_count       <= digit_count_next;
        first_digit_zero  <= first_digit_zero_next;
        fault_seen        <= fault_seen_next;
        address_shift     <= address_shift_next;
      end
      if (load_result) begin
        res_valid <= 1'b1;
      end else if (res_ready) begin
        res_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load_result) begin
      res_addr_valid <= result_ok;
      res_addr_value <= result_ok ? {address_shift[23:0], octet_accumulator} : 32'h0;
    end
  end

endmodule

`default_nettype wire

>>> rtl/ipv4_text_address_parser.sv
// Top level of the dotted-decimal IPv4 text parser.
// Depends on ipv4p_pkg, ipv4p_front, ipv4p_queue, ipv4p_back and the defines header.
//
// The s channel carries one text character per item in s_tdata; an item with
// s_tlast high ends the text and its s_tdata is ignored. Every end-of-text item
// yields exactly one item on the m channel: m_tuser is the valid flag and m_tdata
// the 32-bit address with the first octet in the top byte, or zero when the text
// was malformed. Character items yield no output.
// One item is accepted per cycle when nothing stalls. An end-of-text item passes
// through the classify register and then the token queue, after which it loads the
// output register and the result appears on m_tvalid.
// The parser state updates once per token. When the receiver holds m_tready low,
// character items keep flowing through the back end; only the next end-of-text
// token waits, after which the queue and then s_tready back up.
// Synchronous reset clears the parser state, the queue and the output valid flag;
// after reset the block is ready for a new text at once.
`timescale 1ns / 1ps
`default_nettype none
`include "ipv4_text_address_parser_defines.svh"

module ipv4_text_address_parser #(
  parameter int unsigned QUEUE_DEPTH = ipv4p_pkg::QUEUE_DEPTH
) (
  input  wire         clk,
  input  wire         rst,
  input  wire         s_tvalid,
  output logic        s_tready,
  input  wire  [7:0]  s_tdata,   // [7:0] character
  input  wire         s_tlast,   // end_of_text
  output logic        m_tvalid,
  input  wire         m_tready,
  output logic [31:0] m_tdata,   // [31:0] address_value
  output logic        m_tuser    // address_valid
);

  logic                     front_valid;
  logic                     front_ready;
  ipv4p_pkg::token_t        front_tok;
  logic                     queue_valid;
  logic                     queue_ready;
  ipv4p_pkg::token_t        queue_tok;
  ipv4p_pkg::queue_status_t queue_status;

  ipv4p_front u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_tvalid),
    .in_ready  (s_tready),
    .in_char   (s_tdata),
    .in_eot    (s_tlast),
    .tok_valid (front_valid),
    .tok_ready (front_ready),
    .tok       (front_tok)
  );

  ipv4p_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (front_valid),
    .push_ready (front_ready),
    .push_data  (front_tok),
    .pop_valid  (queue_valid),
    .pop_ready  (queue_ready),
    .pop_data   (queue_tok),
    .status     (queue_status)
  );

  ipv4p_back u_back (
    .clk            (clk),
    .rst            (rst),
    .tok_valid      (queue_valid),
    .tok_ready      (queue_ready),
    .tok            (queue_tok),
    .res_valid      (m_tvalid),
    .res_ready      (m_tready),
    .res_addr_valid (m_tuser),
    .res_addr_value (m_tdata)
  );

  `IPV4P_ASSERT_NEXT(a_accept_fills_front, clk, rst, s_tvalid && s_tready, front_valid)
  `IPV4P_ASSERT_NOW(a_queue_status_sane, clk, rst, 1'b1, !(queue_status.full && queue_status.empty))
  `IPV4P_ASSERT_NOW(a_invalid_result_zero, clk, rst, m_tvalid && !m_tuser, m_tdata == 32'h0)

endmodule

`default_nettype wire

>>> test/ipv4_text_address_parser_checker.sv
// Checker for the dotted-decimal IPv4 text parser: watches both stream channels,
// predicts each result from the accepted text items and compares field by field.
// Depends on ipv4p_pkg for the character constants and the octet count.
`timescale 1ns / 1ps

module ipv4_text_address_parser_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  input  logic        s_tready,
  input  logic [7:0]  s_tdata,
  input  logic        s_tlast,
  input  logic        m_tvalid,
  input  logic        m_tready,
  input  logic [31:0] m_tdata,
  input  logic        m_tuser,
  output int          failures,
  output int          pending
);

  typedef struct packed {
    logic        valid;
    logic [31:0] value;
  } parsed_address_t;

  parsed_address_t expected_addresses[$];
  parsed_address_t oldest;

  logic [2:0]  octets_closed;
  logic [7:0]  octet_value;
  logic [1:0]  octet_digits;
  logic        leading_zero;
  logic        text_bad;
  logic [31:0] address_acc;

  int mismatch_count = 0;
  int in_flight      = 0;

  assign failures = mismatch_count;
  assign pending  = in_flight;

  task automatic clear_text();
    octets_closed = '0;
    octet_value   = '0;
    octet_digits  = '0;
    leading_zero  = 1'b0;
    text_bad      = 1'b0;
    address_acc   = '0;
  endtask

  task automatic close_octet();
    if (octets_closed >= ipv4p_pkg::OCTET_COUNT || octet_digits == 0) begin
      text_bad = 1'b1;
    end else begin
      address_acc   = {address_acc[23:0], octet_value};
      octets_closed = octets_closed + 3'd1;
      octet_value   = '0;
      octet_digits  = '0;
      leading_zero  = 1'b0;
    end
  endtask

  task automatic take_digit(input logic [7:0] d);
    int unsigned grown;
    if (octet_digits == 0) begin
      octet_value  = d;
      leading_zero = (d == 8'd0);
      octet_digits = 2'd1;
    end else if (leading_zero) begin
      text_bad = 1'b1;
    end else begin
      grown = octet_value * 10 + d;
      if (grown > ipv4p_pkg::OCTET_MAX || octet_digits >= 2'd3) begin
        text_bad = 1'b1;
      end else begin
        octet_value  = grown[7:0];
        octet_digits = octet_digits + 2'd1;
      end
    end
  endtask

  task automatic parse_character(input logic [7:0] ch);
    if (!text_bad) begin
      if (ch >= ipv4p_pkg::CHAR_ZERO && ch <= ipv4p_pkg::CHAR_NINE) begin
        take_digit(ch - ipv4p_pkg::CHAR_ZERO);
      end else if (ch == ipv4p_pkg::CHAR_DOT) begin
        close_octet();
      end else begin
        text_bad = 1'b1;
      end
    end
  endtask

  task automatic finish_text();
    parsed_address_t res;
    if (!text_bad) begin
      close_octet();
    end
    if (!text_bad && octets_closed != ipv4p_pkg::OCTET_COUNT) begin
      text_bad = 1'b1;
    end
    res.valid = !text_bad;
    res.value = text_bad ? 32'd0 : address_acc;
    expected_addresses.insert(expected_addresses.size(), res);
    in_flight = in_flight + 1;
    clear_text();
  endtask

  always @(posedge clk) begin
    if (rst) begin
      clear_text();
    end else begin
      if (m_tvalid && m_tready) begin
        if (expected_addresses.size() == 0) begin
          $error("unexpected result: address_valid=%0b address_value=%h", m_tuser, m_tdata);
          mismatch_count = mismatch_count + 1;
        end else begin
          oldest    = expected_addresses.pop_front();
          in_flight = in_flight - 1;
          if (m_tuser !== oldest.valid) begin
            $error("address_valid: expected %0b, got %0b", oldest.valid, m_tuser);
            mismatch_count = mismatch_count + 1;
          end
          if (m_tdata !== oldest.value) begin
            $error("address_value: expected %h, got %h", oldest.value, m_tdata);
            mismatch_count = mismatch_count + 1;
          end
        end
      end
      if (s_tvalid && s_tready) begin
        if (s_tlast) begin
          finish_text();
        end else begin
          parse_character(s_tdata);
        end
      end
    end
  end

endmodule

>>> test/ipv4_text_address_parser_tb.sv
// Testbench top for the dotted-decimal IPv4 text parser: drives directed and random
// texts with random idling on both channels and gives the verdict.
// Depends on ipv4p_pkg, ipv4_text_address_parser and ipv4_text_address_parser_checker.
`timescale 1ns / 1ps

module ipv4_text_address_parser_tb;

  localparam int RANDOM_ITEMS = 1000;
  localparam int HOLD_CYCLES  = 300;
  localparam int IDLE_LIMIT   = 5000;

  logic        clk      = 1'b0;
  logic        rst      = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [7:0]  s_tdata  = 8'd0;
  logic        s_tlast  = 1'b0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [31:0] m_tdata;
  logic        m_tuser;

  int failures;
  int pending;
  int items_sent  = 0;
  int quiet_count = 0;
  int hold_off_req = 0;
  int steady      = 0;

  logic [7:0] text_bytes[$];

  always #1 clk = ~clk;

  ipv4_text_address_parser i_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

  ipv4_text_address_parser_checker i_checker (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .failures (failures),
    .pending  (pending)
  );

  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      quiet_count <= 0;
    end else if (quiet_count >= IDLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end else begin
      quiet_count <= quiet_count + 1;
    end
  end

  function automatic int pick_idle();
    int r;
    r = $urandom_range(0, 99);
    if (steady != 0 || r < 60) begin
      return 0;
    end else if (r < 92) begin
      return $urandom_range(1, 3);
    end else begin
      return $urandom_range(8, 40);
    end
  endfunction

  initial begin
    int on_len;
    int off_len;
    forever begin
      on_len = $urandom_range(1, 8);
      m_tready <= 1'b1;
      repeat (on_len) @(posedge clk);
      if (hold_off_req != 0) begin
        hold_off_req = 0;
        m_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else begin
        off_len = pick_idle();
        if (off_len > 0) begin
          m_tready <= 1'b0;
          repeat (off_len) @(posedge clk);
        end
      end
    end
  end

  task automatic send_item(input logic [7:0] ch, input logic eot);
    int gap;
    gap = pick_idle();
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= ch;
    s_tlast  <= eot;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    items_sent = items_sent + 1;
  endtask

  task automatic add_byte(input logic [7:0] b);
    text_bytes.insert(text_bytes.size(), b);
  endtask

  // The byte carried with the end-of-text item is random, as the block ignores it.
  task automatic send_text();
    for (int i = 0; i < text_bytes.size(); i++) begin
      send_item(text_bytes[i], 1'b0);
    end
    send_item(8'($urandom_range(0, 255)), 1'b1);
  endtask

  task automatic load_string(input string s);
    text_bytes.delete();
    for (int i = 0; i < s.len(); i++) begin
      add_byte(s[i]);
    end
  endtask

  task automatic add_octet(input int v);
    if (v >= 100) begin
      add_byte(ipv4p_pkg::CHAR_ZERO + 8'(v / 100));
    end
    if (v >= 10) begin
      add_byte(ipv4p_pkg::CHAR_ZERO + 8'((v / 10) % 10));
    end
    add_byte(ipv4p_pkg::CHAR_ZERO + 8'(v % 10));
  endtask

  function automatic int random_octet();
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) begin
      return 0;
    end else if (r == 1) begin
      return 255;
    end else if (r == 2) begin
      return $urandom_range(0, 9);
    end else begin
      return $urandom_range(0, 255);
    end
  endfunction

  task automatic build_address();
    text_bytes.delete();
    for (int i = 0; i < ipv4p_pkg::OCTET_COUNT; i++) begin
      if (i > 0) begin
        add_byte(ipv4p_pkg::CHAR_DOT);
      end
      add_octet(random_octet());
    end
  endtask

  task automatic mangle_text();
    int n;
    int r;
    case ($urandom_range(0, 7))
      0: text_bytes.insert($urandom_range(0, text_bytes.size()), 8'($urandom_range(0, 255)));
      1: text_bytes.delete($urandom_range(0, text_bytes.size() - 1));
      2: text_bytes.push_front(ipv4p_pkg::CHAR_ZERO);
      3: begin
        add_byte(ipv4p_pkg::CHAR_DOT);
        add_octet(random_octet());
      end
      4: begin
        n = $urandom_range(1, text_bytes.size());
        repeat (n) void'(text_bytes.pop_back());
      end
      5: text_bytes.insert($urandom_range(0, text_bytes.size()),
                           ipv4p_pkg::CHAR_ZERO + 8'($urandom_range(0, 9)));
      6: begin
        text_bytes.delete();
        n = $urandom_range(0, 6);
        repeat (n) begin
          r = $urandom_range(0, 2);
          if (r == 0) begin
            add_byte(ipv4p_pkg::CHAR_DOT);
          end else if (r == 1) begin
            add_byte(ipv4p_pkg::CHAR_ZERO + 8'($urandom_range(0, 9)));
          end else begin
            add_byte(8'($urandom_range(0, 255)));
          end
        end
      end
      default: text_bytes.push_front(ipv4p_pkg::CHAR_ZERO + 8'($urandom_range(1, 9)));
    endcase
  endtask

  initial begin
    int text_no;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    text_bytes.delete();
    send_text();
    load_string("0.255.0.9");
    send_text();
    load_string(".");
    send_text();
    load_string("00");
    send_text();
    load_string("256");
    send_text();
    load_string("0.0.0.0.");
    send_text();
    load_string("1.2");
    send_text();
    // A byte with every bit set faults the text; the bytes after it are ignored.
    text_bytes.delete();
    add_byte(8'hFF);
    add_byte(ipv4p_pkg::CHAR_ZERO + 8'd9);
    add_byte(8'h00);
    send_text();

    text_no = 0;
    while (items_sent < RANDOM_ITEMS) begin
      if (text_no == 10) begin
        hold_off_req = 1;
      end
      if (text_no == 25) begin
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
      end
      steady = (text_no >= 40 && text_no < 50) ? 1 : 0;
      build_address();
      if ($urandom_range(0, 99) < 30) begin
        mangle_text();
      end
      send_text();
      text_no = text_no + 1;
    end
    s_tvalid <= 1'b0;

    while (pending != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (failures == 0 && pending == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
